FILE: design/pcc_pkg.sv
// Shared types, widths and codes for the Pearson correlation block.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_PAIRS   = 4096;

    localparam int CNT_W   = $clog2(MAX_PAIRS + 1);
    localparam int SUM_W   = SAMPLE_BITS + CNT_W;
    localparam int SQ_W    = 2 * SAMPLE_BITS + CNT_W - 2;
    localparam int XY_W    = SQ_W + 1;
    localparam int PROD_W  = CNT_W + SQ_W;
    localparam int COV_W   = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int VAR_W   = PROD_W;
    localparam int DEN_W   = 2 * VAR_W;
    localparam int NUM_W   = 2 * MAG_W + 32;
    localparam int MUL_A_W = DEN_W;
    localparam int MUL_B_W = MAG_W;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int COEF_W  = 16;
    localparam int Q_W     = 16;
    localparam int BIT_W   = $clog2(Q_W);
    localparam int ODD_W   = Q_W + 1;
    localparam int SQR_W   = 2 * ODD_W;

    localparam int S_DATA_W = ((2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((COEF_W + CNT_W + 7) / 8) * 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [CNT_W-1:0]        n;
        logic signed [SUM_W-1:0] sx;
        logic signed [SUM_W-1:0] sy;
        logic [SQ_W-1:0]         sxx;
        logic [SQ_W-1:0]         syy;
        logic signed [XY_W-1:0]  sxy;
        logic                    dropped;
    } pcc_sums_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_SQUARE,
        ST_OUT
    } pcc_state_t;

    typedef enum logic [3:0] {
        STP_COV_A,
        STP_COV_B,
        STP_VX_A,
        STP_VX_B,
        STP_VY_A,
        STP_VY_B,
        STP_DEN,
        STP_NUM,
        STP_TRIAL
    } pcc_step_t;

endpackage

FILE: design/pearson_correlation_top.sv
// Top level of the streaming Pearson correlation block.
// Depends on pcc_pkg, pcc_front, pcc_fifo, pcc_back (and pcc_mul below it).
`timescale 1ns / 1ps

// Usage
// The input channel (s_) carries one sample pair per request: x and y in
// s_tdata, the pair-valid mark in s_tuser and the end-of-set mark in s_tlast.
// Pairs marked valid are summed until the capacity is reached; later valid
// pairs are dropped and flagged. A request with s_tlast closes the set, and
// exactly one result request follows on the output channel (m_).
// Throughput: the front end takes one pair every cycle. A closed set is held
// in a two-entry queue, so the front end only stalls when two closed sets
// are already waiting for the back end.
// Back end: one shift-and-add multiplier does all the work. Six products
// form the covariance and variances, two more the squared terms, then
// sixteen trial products fix the result one bit at a time; a degenerate
// set stops after the first six products.
// Reset (aresetn low at a clock edge) clears the sums, the queue and any
// pending result. When the receiver holds m_tready low the result waits in
// its output register while the next set is already being worked on.

module pearson_correlation_top
    import pcc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // x_sample, y_sample
    input  logic                s_tuser,   // pair_valid
    input  logic                s_tlast,   // last_pair
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // coefficient, pairs_used, zero fill
    output logic [1:0]          m_tuser    // degenerate, overflowed
);

    logic      q_push, q_full, q_pop, q_not_empty;
    pcc_sums_t q_din, q_dout;

    pcc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_din    (q_din)
    );

    // Closed sets wait here while the back end is busy.
    pcc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .din       (q_din),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .dout      (q_dout)
    );

    pcc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (q_not_empty),
        .job       (q_dout),
        .job_pop   (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

FILE: design/pcc_front.sv
// Front end: takes sample pairs and keeps the running count and sums.
// Depends on pcc_pkg; hands finished sets to the queue as pcc_sums_t.
`timescale 1ns / 1ps

module pcc_front
    import pcc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                s_tlast,
    input  logic                q_full,
    output logic                q_push,
    output pcc_sums_t           q_din
);

    pcc_sums_t acc_reg, acc_next;

    logic signed [SAMPLE_BITS-1:0]   x, y;
    logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;
    logic accept, take, drop;

    always_comb begin
        x        = s_tdata[SAMPLE_BITS-1:0];
        y        = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        xx       = x * x;
        yy       = y * y;
        xy       = x * y;
        s_tready = !q_full;
        accept   = s_tvalid && s_tready;
        take     = accept && s_tuser && (acc_reg.n < CNT_W'(MAX_PAIRS));
        drop     = accept && s_tuser && !(acc_reg.n < CNT_W'(MAX_PAIRS));
        acc_next = acc_reg;
        if (take) begin
            acc_next.n   = acc_reg.n + CNT_W'(1);
            acc_next.sx  = acc_reg.sx + {{(SUM_W-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
            acc_next.sy  = acc_reg.sy + {{(SUM_W-SAMPLE_BITS){y[SAMPLE_BITS-1]}}, y};
            acc_next.sxx = acc_reg.sxx + {{(SQ_W-2*SAMPLE_BITS){1'b0}}, xx};
            acc_next.syy = acc_reg.syy + {{(SQ_W-2*SAMPLE_BITS){1'b0}}, yy};
            acc_next.sxy = acc_reg.sxy + {{(XY_W-2*SAMPLE_BITS){xy[2*SAMPLE_BITS-1]}}, xy};
        end
        if (drop) begin
            acc_next.dropped = 1'b1;
        end
        q_push = accept && s_tlast;
        q_din  = acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || q_push) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg.n <= CNT_W'(MAX_PAIRS))
        else $error("pair count beyond capacity");

endmodule

FILE: design/pcc_fifo.sv
// Short queue of finished sets between the front and back ends.
// Depends on pcc_pkg for the entry type and depth.
`timescale 1ns / 1ps

module pcc_fifo
    import pcc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  pcc_sums_t din,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output pcc_sums_t dout
);

    pcc_sums_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_reg, rd_reg;
    logic [QCNT_W-1:0]  cnt_reg;

    always_comb begin
        full      = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
        not_empty = (cnt_reg != '0);
        dout      = entry_reg[rd_reg];
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

endmodule

FILE: design/pcc_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, early finish.
// Depends on pcc_pkg for operand widths.
`timescale 1ns / 1ps

module pcc_mul
    import pcc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic               busy,
    output logic               done,
    output logic [MUL_P_W-1:0] product
);

    logic [MUL_P_W-1:0] a_reg, acc_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic               busy_reg, done_reg;

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= MUL_P_W'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (b_reg[MUL_B_W-1:1] == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

endmodule

FILE: design/pcc_back.sv
// Back end: turns a finished set of sums into the Q1.15 coefficient.
// Depends on pcc_pkg and pcc_mul; drives the result channel.
`timescale 1ns / 1ps

module pcc_back
    import pcc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    input  pcc_sums_t           job,
    output logic                job_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,
    output logic [1:0]          m_tuser
);

    pcc_state_t state_reg, state_next;
    pcc_step_t  step_reg, step_next;
    pcc_sums_t  job_reg;

    logic signed [COV_W-1:0] cov_reg, cov_next;
    logic [VAR_W-1:0]  vx_reg, vx_next, vy_reg, vy_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [NUM_W-1:0]  num_reg, num_next;
    logic [Q_W-1:0]    q_reg, q_next, cand, qc;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [SQR_W-1:0]  sq_reg, sq_next;
    logic              degen_reg, degen_next;
    logic [ODD_W-1:0]  odd;

    logic               m_valid_reg, m_valid_next;
    logic [COEF_W-1:0]  coef_reg, coef_next;
    logic [CNT_W-1:0]   n_out_reg;
    logic               degen_out_reg, ovf_out_reg, out_load;

    logic               mul_start, mul_busy, mul_done;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;

    logic [SUM_W-1:0]        sx_mag, sy_mag;
    logic [XY_W-1:0]         sxy_mag;
    logic [MAG_W-1:0]        cov_mag;
    logic signed [COV_W-1:0] p_cov, cov_term;
    logic [VAR_W:0]          var_diff;

    pcc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .product (mul_p)
    );

    // Magnitudes and operand selection for the current step
    always_comb begin
        sx_mag  = job_reg.sx[SUM_W-1] ? SUM_W'(-job_reg.sx) : SUM_W'(job_reg.sx);
        sy_mag  = job_reg.sy[SUM_W-1] ? SUM_W'(-job_reg.sy) : SUM_W'(job_reg.sy);
        sxy_mag = job_reg.sxy[XY_W-1] ? XY_W'(-job_reg.sxy) : XY_W'(job_reg.sxy);
        cov_mag = cov_reg[COV_W-1] ? MAG_W'(-cov_reg) : MAG_W'(cov_reg);
        cand    = q_reg | (Q_W'(1) << bit_reg);
        odd     = {cand, 1'b0} - ODD_W'(1);
        case (step_reg)
            STP_COV_A: begin
                mul_a = MUL_A_W'(sxy_mag);
                mul_b = MUL_B_W'(job_reg.n);
            end
            STP_COV_B: begin
                mul_a = MUL_A_W'(sx_mag);
                mul_b = MUL_B_W'(sy_mag);
            end
            STP_VX_A: begin
                mul_a = MUL_A_W'(job_reg.sxx);
                mul_b = MUL_B_W'(job_reg.n);
            end
            STP_VX_B: begin
                mul_a = MUL_A_W'(sx_mag);
                mul_b = MUL_B_W'(sx_mag);
            end
            STP_VY_A: begin
                mul_a = MUL_A_W'(job_reg.syy);
                mul_b = MUL_B_W'(job_reg.n);
            end
            STP_VY_B: begin
                mul_a = MUL_A_W'(sy_mag);
                mul_b = MUL_B_W'(sy_mag);
            end
            STP_DEN: begin
                mul_a = MUL_A_W'(vx_reg);
                mul_b = MUL_B_W'(vy_reg);
            end
            STP_NUM: begin
                mul_a = MUL_A_W'(cov_mag);
                mul_b = MUL_B_W'(cov_mag);
            end
            STP_TRIAL: begin
                mul_a = MUL_A_W'(den_reg);
                mul_b = MUL_B_W'(sq_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Result formatting: round(|r| * 2^15), clamped, signed
    always_comb begin
        qc = (q_reg > Q_W'(32768)) ? Q_W'(32768) : q_reg;
        if (degen_reg) begin
            coef_next = '0;
        end else if (cov_reg[COV_W-1]) begin
            coef_next = COEF_W'(-qc);
        end else begin
            coef_next = (qc > Q_W'(32767)) ? COEF_W'(32767) : COEF_W'(qc);
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cov_next     = cov_reg;
        vx_next      = vx_reg;
        vy_next      = vy_reg;
        den_next     = den_reg;
        num_next     = num_reg;
        q_next       = q_reg;
        bit_next     = bit_reg;
        sq_next      = sq_reg;
        degen_next   = degen_reg;
        job_pop      = 1'b0;
        mul_start    = 1'b0;
        out_load     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        p_cov        = signed'({1'b0, mul_p[COV_W-2:0]});
        cov_term     = '0;
        var_diff     = {1'b0, vx_reg} - {1'b0, mul_p[VAR_W-1:0]};
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_pop    = 1'b1;
                    degen_next = 1'b0;
                    step_next  = STP_COV_A;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                mul_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (mul_done) begin
                    state_next = ST_START;
                    case (step_reg)
                        STP_COV_A: begin
                            cov_next  = job_reg.sxy[XY_W-1] ? -p_cov : p_cov;
                            step_next = STP_COV_B;
                        end
                        STP_COV_B: begin
                            cov_term  = (job_reg.sx[SUM_W-1] ^ job_reg.sy[SUM_W-1])
                                        ? -p_cov : p_cov;
                            cov_next  = cov_reg - cov_term;
                            step_next = STP_VX_A;
                        end
                        STP_VX_A: begin
                            vx_next   = mul_p[VAR_W-1:0];
                            step_next = STP_VX_B;
                        end
                        STP_VX_B: begin
                            vx_next   = var_diff[VAR_W-1:0];
                            step_next = STP_VY_A;
                        end
                        STP_VY_A: begin
                            vy_next   = mul_p[VAR_W-1:0];
                            step_next = STP_VY_B;
                        end
                        STP_VY_B: begin
                            var_diff = {1'b0, vy_reg} - {1'b0, mul_p[VAR_W-1:0]};
                            vy_next  = var_diff[VAR_W-1:0];
                            if ((job_reg.n < CNT_W'(2)) || (vx_reg == '0) ||
                                (vy_next == '0)) begin
                                degen_next = 1'b1;
                                state_next = ST_OUT;
                            end else begin
                                step_next = STP_DEN;
                            end
                        end
                        STP_DEN: begin
                            den_next  = mul_p[DEN_W-1:0];
                            step_next = STP_NUM;
                        end
                        STP_NUM: begin
                            num_next   = {mul_p[2*MAG_W-1:0], 32'd0};
                            q_next     = '0;
                            bit_next   = BIT_W'(Q_W - 1);
                            step_next  = STP_TRIAL;
                            state_next = ST_SQUARE;
                        end
                        STP_TRIAL: begin
                            if (mul_p <= MUL_P_W'(num_reg)) begin
                                q_next = cand;
                            end
                            if (bit_reg == '0) begin
                                state_next = ST_OUT;
                            end else begin
                                bit_next   = bit_reg - BIT_W'(1);
                                state_next = ST_SQUARE;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SQUARE: begin
                sq_next    = odd * odd;
                state_next = ST_START;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= STP_COV_A;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) begin
            job_reg <= job;
        end
        cov_reg   <= cov_next;
        vx_reg    <= vx_next;
        vy_reg    <= vy_next;
        den_reg   <= den_next;
        num_reg   <= num_next;
        q_reg     <= q_next;
        bit_reg   <= bit_next;
        sq_reg    <= sq_next;
        degen_reg <= degen_next;
        if (out_load) begin
            coef_reg      <= coef_next;
            n_out_reg     <= job_reg.n;
            degen_out_reg <= degen_reg;
            ovf_out_reg   <= job_reg.dropped;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({n_out_reg, coef_reg});
    assign m_tuser  = {ovf_out_reg, degen_out_reg};

    a_mul_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    a_var_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT && mul_done && step_reg == STP_VX_B) |-> !var_diff[VAR_W])
        else $error("x variance term negative");

    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> job_valid)
        else $error("set taken from empty queue");

    a_out_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg)
        else $error("loaded result not presented");

endmodule
